FILE: hw/rtl/msb_pkg.sv
`timescale 1ns / 1ps
// Shared types for the multi-stack shared buffer: result status codes,
// controller states and the controller-to-datapath command bundle.
// No dependencies.
package msb_pkg;

   localparam logic KIND_PUSH = 1'b0;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

FILE: hw/rtl/msb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/msb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the multi-stack shared buffer: accept, execute, result valid.
// Depends on msb_pkg.
module msb_ctrl
   import msb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      req_stall   = (state_ff != S_IDLE);
      cmd.capture = req_valid && (state_ff == S_IDLE);
      cmd.execute = (state_ff == S_EXEC) && out_free;
      state_in    = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.execute) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.execute || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_EXEC)
      else $error("capture did not enter execute");

   a_execute_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("executed item produced no result");

   a_exec_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !cmd.execute) |=> state_ff == S_EXEC && rsp_valid_ff)
      else $error("execute left while output busy");

endmodule

FILE: hw/rtl/msb_dp.sv
`timescale 1ns / 1ps
// Datapath: stack heads, slot occupancy, lowest-free search, value and link RAMs,
// result register. Depends on msb_pkg and msb_ram.
module msb_dp
   import msb_pkg::*;
#(
   parameter int SLOT_COUNT  = 16,
   parameter int STACK_COUNT = 4,
   parameter int VALUE_BITS  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               req_kind,
   input  logic [1:0]         req_stack_id,
   input  logic signed [31:0] req_push_value,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_popped_value,
   output logic [3:0]         rsp_slot_used_index
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int HEAD_W = SLOT_W + 1;
   localparam int SID_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
   localparam logic [HEAD_W-1:0] EMPTY = HEAD_W'(SLOT_COUNT);

   logic [HEAD_W-1:0]     head_ff [STACK_COUNT];
   logic [SLOT_COUNT-1:0] busy_ff, busy_in;

   logic                  kind_ff;
   logic                  sid_ok_ff;
   logic [SID_W-1:0]      sid_idx_ff;
   logic [HEAD_W-1:0]     top_ff;
   logic [VALUE_BITS-1:0] value_ff;

   status_type            status_ff, status_in;
   logic [31:0]           popped_ff, popped_in;
   logic [3:0]            slot_out_ff, slot_out_in;

   logic [SID_W-1:0]      req_sid_idx;
   logic                  req_sid_ok;
   logic [HEAD_W-1:0]     req_top;
   logic signed [63:0]    push_ext;

   logic                  free_found;
   logic [SLOT_W-1:0]     free_idx;
   logic                  push_ok;
   logic                  pop_ok;
   logic                  top_empty;
   logic [HEAD_W-1:0]     slot_pick;

   logic [VALUE_BITS-1:0] val_rd;
   logic [HEAD_W-1:0]     link_rd;
   logic signed [63:0]    pop_ext;

   always_comb begin
      req_sid_idx = SID_W'(req_stack_id);
      req_sid_ok  = (32'(req_stack_id) < STACK_COUNT);
      req_top     = req_sid_ok ? head_ff[req_sid_idx] : EMPTY;
      push_ext    = 64'(req_push_value);
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   msb_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOT_COUNT)) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.execute && push_ok),
      .wr_addr (free_idx),
      .wr_data (value_ff),
      .rd_en   (cmd.capture),
      .rd_addr (req_top[SLOT_W-1:0]),
      .rd_data (val_rd)
   );

   msb_ram #(.WIDTH(HEAD_W), .DEPTH(SLOT_COUNT)) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.execute && push_ok),
      .wr_addr (free_idx),
      .wr_data (top_ff),
      .rd_en   (cmd.capture),
      .rd_addr (req_top[SLOT_W-1:0]),
      .rd_data (link_rd)
   );

   always_comb begin
      top_empty = (top_ff == EMPTY);
      push_ok   = (kind_ff == KIND_PUSH) && sid_ok_ff && free_found;
      pop_ok    = (kind_ff != KIND_PUSH) && !top_empty;
      pop_ext   = 64'($signed(val_rd));
      busy_in   = busy_ff;
      if (push_ok) begin
         busy_in[free_idx] = 1'b1;
      end else if (pop_ok) begin
         busy_in[top_ff[SLOT_W-1:0]] = 1'b0;
      end
      priority if (push_ok) begin
         status_in = ST_OK;
         slot_pick = {1'b0, free_idx};
      end else if (pop_ok) begin
         status_in = ST_OK;
         slot_pick = top_ff;
      end else if (kind_ff == KIND_PUSH) begin
         status_in = ST_OVERFLOW;
         slot_pick = '0;
      end else begin
         status_in = ST_UNDERFLOW;
         slot_pick = '0;
      end
      popped_in   = pop_ok ? pop_ext[31:0] : 32'd0;
      slot_out_in = 4'(slot_pick);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int s = 0; s < STACK_COUNT; s++) begin
            head_ff[s] <= EMPTY;
         end
      end else if (cmd.execute) begin
         busy_ff <= busy_in;
         if (push_ok) begin
            head_ff[sid_idx_ff] <= {1'b0, free_idx};
         end else if (pop_ok) begin
            head_ff[sid_idx_ff] <= link_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         sid_ok_ff  <= req_sid_ok;
         sid_idx_ff <= req_sid_idx;
         top_ff     <= req_top;
         value_ff   <= push_ext[VALUE_BITS-1:0];
      end
      if (cmd.execute) begin
         status_ff   <= status_in;
         popped_ff   <= popped_in;
         slot_out_ff <= slot_out_in;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_popped_value    = popped_ff;
   assign rsp_slot_used_index = slot_out_ff;

   a_push_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && push_ok) |=> busy_ff[$past(free_idx)])
      else $error("pushed slot not marked busy");

   a_pop_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && pop_ok) |=> !busy_ff[$past(top_ff[SLOT_W-1:0])])
      else $error("popped slot still busy");

   a_refused_is_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && !push_ok && !pop_ok)
         |=> status_ff != ST_OK && popped_ff == 32'd0 && slot_out_ff == 4'd0)
      else $error("refused operation returned data");

endmodule

FILE: hw/rtl/multi_stack_shared_buffer.sv
`timescale 1ns / 1ps
// Several LIFO stacks sharing one linked slot store.
// Depends on msb_pkg, msb_ctrl, msb_dp (which uses msb_ram).
//
//   channel  direction  payload                                   handshake
//   req_     in         kind, stack_id, push_value                req_valid / req_stall
//   rsp_     out        status, popped_value, slot_used_index     rsp_valid / rsp_stall
//
// Each operation has a read step, which reads the addressed head's value and link
// from the slot RAMs, and an update step, which searches the lowest free slot and
// updates heads, occupancy and RAMs. The result sits in an output register; the next
// request is taken while it waits. Synchronous reset empties all stacks and frees all
// slots at once. A stalled result holds the update step of the following item.
module multi_stack_shared_buffer
   import msb_pkg::*;
#(
   parameter int SLOT_COUNT  = 16,
   parameter int STACK_COUNT = 4,
   parameter int VALUE_BITS  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [1:0]         req_stack_id,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_popped_value,
   output logic [3:0]         rsp_slot_used_index
);

   cmd_type cmd;

   msb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   msb_dp #(
      .SLOT_COUNT  (SLOT_COUNT),
      .STACK_COUNT (STACK_COUNT),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_kind            (req_kind),
      .req_stack_id        (req_stack_id),
      .req_push_value      (req_push_value),
      .rsp_status          (rsp_status),
      .rsp_popped_value    (rsp_popped_value),
      .rsp_slot_used_index (rsp_slot_used_index)
   );

endmodule
